>>> hdl/bal_pkg.sv
package bal_pkg;

	localparam int BAL_DEPTH      = 16;
	localparam int BAL_DATA_WIDTH = 32;
	localparam int BAL_LIMIT_W    = 5;
	localparam int BAL_POS_W      = 5;
	localparam int BAL_VALUE_W    = 32;
	localparam logic [BAL_LIMIT_W-1:0] BAL_LIMIT_RESET = 5'd16;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_INSERT_AT  = 3'd4,
		OP_READ_LAST  = 3'd5,
		OP_SEARCH     = 3'd6
	} bal_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_OUT
	} bal_state_t;

	// broadcast command to every cell
	typedef struct packed {
		logic ins;   // open a gap at 'at', shift up
		logic del;   // drop cell 0, shift down
		logic srch;  // compare against word
		logic pick;  // flag the last held cell
	} bal_cmd_t;

endpackage

>>> hdl/bal_cell.sv
module bal_cell #(
	parameter int DATA_WIDTH = bal_pkg::BAL_DATA_WIDTH,
	parameter int CW         = 5,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bal_pkg::bal_cmd_t     cmd,
	input  logic [CW-1:0]         at,
	input  logic [CW-1:0]         cnt,
	input  logic [DATA_WIDTH-1:0] word_in,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] word_q,
	output logic                  hit_s1,
	output logic                  pick_s1
);

	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [CW-1:0] IDX1_C = CW'(IDX + 1);

	logic [DATA_WIDTH-1:0] word_d;

	always_comb begin
		word_d = word_q;
		if (cmd.ins) begin
			if (IDX_C == at)
				word_d = word_in;
			else if (IDX_C > at && IDX_C <= cnt)
				word_d = left;
		end else if (cmd.del) begin
			if (IDX1_C < cnt)
				word_d = right;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1  <= 1'b0;
			pick_s1 <= 1'b0;
		end else begin
			hit_s1  <= cmd.srch && (IDX_C < cnt) && (word_q == word_in);
			pick_s1 <= cmd.pick && (IDX1_C == cnt);
		end
	end

endmodule

>>> hdl/bal_reduce.sv
module bal_reduce #(
	parameter int DATA_WIDTH = bal_pkg::BAL_DATA_WIDTH,
	parameter int DEPTH      = bal_pkg::BAL_DEPTH
) (
	input  logic [DATA_WIDTH-1:0] words [DEPTH],
	input  logic [DEPTH-1:0]      hit,
	input  logic [DEPTH-1:0]      pick,
	output logic                  any_hit,
	output logic [DATA_WIDTH-1:0] pick_word
);

	always_comb begin
		pick_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			pick_word = pick_word | (words[i] & {DATA_WIDTH{pick[i]}});
		end
	end

	assign any_hit = |hit;

endmodule

>>> hdl/bounded_array_list.sv
// Sequencing: the input transaction updates the cells, ST_REDUCE registers the reduced
// result, then ST_OUT holds m_tvalid until m_tready. No new transaction is taken before
// then; the accept/reduce/output sequencer holds one operation at a time.
// Reset: entry count cleared, size limit set to 16, cell contents undefined
// until written; no clearing pass.
module bounded_array_list #(
	parameter int DEPTH      = bal_pkg::BAL_DEPTH,
	parameter int DATA_WIDTH = bal_pkg::BAL_DATA_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[4:0], value[36:5], zero pad
	input  logic [2:0]  s_tuser,   // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // accepted[0], data_out[32:1], found[33],
	                               // count[38:34], is_empty[39], is_full[40], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data   // size_limit
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > bal_pkg::BAL_LIMIT_W) ? CW : bal_pkg::BAL_LIMIT_W;

	bal_pkg::bal_state_t state_q, state_d;
	bal_pkg::bal_cmd_t   cmd;

	logic [bal_pkg::BAL_LIMIT_W-1:0] limit_q;
	logic [CW-1:0]                   count_q, count_d;
	logic [CW-1:0]                   at;
	logic                            acc_s1;
	logic [47:0]                     m_tdata_q;

	logic                   take, load_out;
	logic                   ok, dec;
	logic [LW-1:0]          cnt_ext, lim_ext, lim, pos_ext;
	logic                   full;
	logic [63:0]            val_ext;
	logic [DATA_WIDTH-1:0]  word_in;
	logic [DATA_WIDTH-1:0]  words [DEPTH];
	logic [DEPTH-1:0]       hit_v, pick_v;
	logic                   any_hit;
	logic [DATA_WIDTH-1:0]  pick_word;
	logic [63:0]            pick_ext;
	bal_pkg::bal_op_t       op;

	assign cfg_ready = 1'b1;
	assign take      = s_tvalid && s_tready;
	assign op        = bal_pkg::bal_op_t'(s_tuser);

	assign val_ext = {32'b0, s_tdata[36:5]};
	assign word_in = val_ext[DATA_WIDTH-1:0];

	assign cnt_ext = LW'(count_q);
	assign lim_ext = LW'(limit_q);
	assign lim     = (lim_ext > LW'(DEPTH)) ? LW'(DEPTH) : lim_ext;
	assign full    = cnt_ext >= lim;
	assign pos_ext = LW'(s_tdata[4:0]);

	always_comb begin
		cmd = '0;
		ok  = 1'b0;
		dec = 1'b0;
		at  = '0;
		case (op)
			bal_pkg::OP_PUSH_FRONT: begin
				ok = !full;
			end
			bal_pkg::OP_PUSH_BACK: begin
				ok = !full;
				at = count_q;
			end
			bal_pkg::OP_POP_BACK: begin
				ok       = count_q != '0;
				dec      = ok;
				cmd.pick = ok && take;
			end
			bal_pkg::OP_POP_FRONT: begin
				ok      = count_q != '0;
				dec     = ok;
				cmd.del = ok && take;
			end
			bal_pkg::OP_INSERT_AT: begin
				ok = !full && (pos_ext <= cnt_ext);
				at = pos_ext[CW-1:0];
			end
			bal_pkg::OP_READ_LAST: begin
				ok       = count_q != '0;
				cmd.pick = ok && take;
			end
			bal_pkg::OP_SEARCH: begin
				ok       = 1'b1;
				cmd.srch = take;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (op == bal_pkg::OP_PUSH_FRONT || op == bal_pkg::OP_PUSH_BACK ||
		    op == bal_pkg::OP_INSERT_AT)
			cmd.ins = ok && take;
	end

	always_comb begin
		count_d = count_q;
		if (cmd.ins)
			count_d = count_q + CW'(1);
		else if (take && dec)
			count_d = count_q - CW'(1);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left, right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = words[i+1];
		end
		bal_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.CW        (CW),
			.IDX       (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.at     (at),
			.cnt    (count_q),
			.word_in(word_in),
			.left   (left),
			.right  (right),
			.word_q (words[i]),
			.hit_s1 (hit_v[i]),
			.pick_s1(pick_v[i])
		);
	end

	bal_reduce #(
		.DATA_WIDTH(DATA_WIDTH),
		.DEPTH     (DEPTH)
	) u_reduce (
		.words    (words),
		.hit      (hit_v),
		.pick     (pick_v),
		.any_hit  (any_hit),
		.pick_word(pick_word)
	);

	assign pick_ext = 64'(pick_word);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bal_pkg::ST_IDLE:   if (s_tvalid) state_d = bal_pkg::ST_REDUCE;
			bal_pkg::ST_REDUCE: state_d = bal_pkg::ST_OUT;
			bal_pkg::ST_OUT:    if (m_tready) state_d = bal_pkg::ST_IDLE;
			default:            state_d = bal_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		load_out = 1'b0;
		case (state_q)
			bal_pkg::ST_IDLE:   s_tready = 1'b1;
			bal_pkg::ST_REDUCE: load_out = 1'b1;
			bal_pkg::ST_OUT:    m_tvalid = 1'b1;
			default:            s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bal_pkg::ST_IDLE;
			count_q <= '0;
			limit_q <= bal_pkg::BAL_LIMIT_RESET;
			acc_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_valid && cfg_ready)
				limit_q <= cfg_data;
			if (take)
				acc_s1 <= ok;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			m_tdata_q <= {7'b0, full, count_q == '0, cnt_ext[4:0], any_hit,
			              pick_ext[31:0], acc_s1};
	end

	assign m_tdata = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the count");

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.del || cmd.pick) |-> count_q != '0)
		else $error("removal on empty list");

	a_pick_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pick_v))
		else $error("more than one cell picked");

endmodule
